>>> hdl/cuc_pkg.sv
// Shared types and constants for the CUC time code byte parser.
// Used by all modules under hdl/; no dependencies.
package cuc_pkg;

  // Result status codes
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Time code ids
  localparam logic [2:0] TC_LEVEL1 = 3'd1;
  localparam logic [2:0] TC_AGENCY = 3'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PFIELD     = 2'd0;
  localparam logic [1:0] REG_DEF_TC     = 2'd1;
  localparam logic [1:0] REG_DEF_BASE   = 2'd2;
  localparam logic [1:0] REG_DEF_FRAC   = 2'd3;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned SECS_W     = 64;
  localparam int unsigned OUT_DATA_W = 72;

  // Seconds between the CCSDS epoch and the DTN epoch
  localparam logic [SECS_W-1:0] EPOCH_OFFSET = 64'd1325376000;

  typedef struct packed {
    logic       pfield_present;
    logic [2:0] default_time_code;
    logic [3:0] default_base_octets;
    logic [3:0] default_frac_octets;
  } cfg_t;

  typedef struct packed {
    logic              seconds_valid;
    logic [SECS_W-1:0] dtn_seconds;
    logic [1:0]        parse_status;
  } result_t;

endpackage

>>> hdl/cuc_parse_core.sv
// Parser state registers and per-octet next-state logic.
// Depends on cuc_pkg.
module cuc_parse_core
  import cuc_pkg::*;
#(
  parameter int unsigned MAX_BASE_OCTETS = 8,
  parameter int unsigned MAX_FRAC_OCTETS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       first_byte,
  output result_t    res
);

  localparam int unsigned ACC_W  = 8 * MAX_BASE_OCTETS;
  localparam int unsigned BASE_W = $clog2(MAX_BASE_OCTETS + 1);
  localparam int unsigned FRAC_W = $clog2(MAX_FRAC_OCTETS + 1);
  localparam int unsigned SUM_W  = 5;
  localparam logic [SUM_W-1:0] MAX_B = SUM_W'(MAX_BASE_OCTETS);
  localparam logic [SUM_W-1:0] MAX_F = SUM_W'(MAX_FRAC_OCTETS);

  typedef enum logic [1:0] {PH_START, PH_PRE, PH_BASE, PH_FRAC} phase_t;

  phase_t            phase_r, phase_nxt, ph_eff, body_ph;
  logic [2:0]        type_r, type_nxt, type_eff, body_tc;
  logic [BASE_W-1:0] btot_r, btot_nxt, btot_eff;
  logic [FRAC_W-1:0] ftot_r, ftot_nxt, ftot_eff;
  logic [BASE_W-1:0] bleft_r, bleft_nxt, bleft_eff, body_bl;
  logic [FRAC_W-1:0] fleft_r, fleft_nxt, fleft_eff, body_fl;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_eff;
  logic              do_body;
  logic [1:0]        st;
  logic [SUM_W-1:0]  nb, nf;
  logic [SECS_W-1:0] acc64;

  always_comb begin
    // first_byte restarts the parse before this octet
    ph_eff    = first_byte ? PH_START : phase_r;
    type_eff  = first_byte ? '0 : type_r;
    btot_eff  = first_byte ? '0 : btot_r;
    ftot_eff  = first_byte ? '0 : ftot_r;
    bleft_eff = first_byte ? '0 : bleft_r;
    fleft_eff = first_byte ? '0 : fleft_r;
    acc_eff   = first_byte ? '0 : acc_r;

    phase_nxt = ph_eff;
    type_nxt  = type_eff;
    btot_nxt  = btot_eff;
    ftot_nxt  = ftot_eff;
    bleft_nxt = bleft_eff;
    fleft_nxt = fleft_eff;
    acc_nxt   = acc_eff;
    st        = ST_MORE;
    do_body   = 1'b0;
    body_ph   = ph_eff;
    body_tc   = type_eff;
    body_bl   = bleft_eff;
    body_fl   = fleft_eff;
    nb        = '0;
    nf        = '0;

    case (ph_eff)
      PH_START: begin
        if (cfg.pfield_present) begin
          type_nxt = byte_in[6:4];
          nb = {3'b0, byte_in[3:2]} + SUM_W'(1);
          nf = {3'b0, byte_in[1:0]};
          if (byte_in[6:4] != TC_LEVEL1 && byte_in[6:4] != TC_AGENCY) begin
            st = ST_ERR;
          end else if (nb > MAX_B || nf > MAX_F) begin
            st = ST_ERR;
          end else begin
            btot_nxt = nb[BASE_W-1:0];
            ftot_nxt = nf[FRAC_W-1:0];
            if (byte_in[7]) begin
              phase_nxt = PH_PRE;
            end else begin
              bleft_nxt = nb[BASE_W-1:0];
              fleft_nxt = nf[FRAC_W-1:0];
              phase_nxt = PH_BASE;
            end
          end
        end else begin
          nb = {1'b0, cfg.default_base_octets};
          nf = {1'b0, cfg.default_frac_octets};
          if (cfg.default_time_code != TC_LEVEL1 || nb == '0 || nb > MAX_B || nf > MAX_F) begin
            st = ST_ERR;
          end else begin
            // no preamble: this octet is already the first base octet
            do_body = 1'b1;
            body_ph = PH_BASE;
            body_tc = TC_LEVEL1;
            body_bl = nb[BASE_W-1:0];
            body_fl = nf[FRAC_W-1:0];
            type_nxt = TC_LEVEL1;
            btot_nxt = nb[BASE_W-1:0];
            ftot_nxt = nf[FRAC_W-1:0];
          end
        end
      end
      PH_PRE: begin
        nb = SUM_W'(btot_eff) + {3'b0, byte_in[6:5]};
        nf = SUM_W'(ftot_eff) + {2'b0, byte_in[4:2]};
        if (nb > MAX_B || nf > MAX_F) begin
          st = ST_ERR;
        end else begin
          btot_nxt = nb[BASE_W-1:0];
          ftot_nxt = nf[FRAC_W-1:0];
          if (!byte_in[7]) begin
            bleft_nxt = nb[BASE_W-1:0];
            fleft_nxt = nf[FRAC_W-1:0];
            phase_nxt = PH_BASE;
          end
        end
      end
      default: begin
        do_body = 1'b1;
      end
    endcase

    if (do_body) begin
      phase_nxt = body_ph;
      bleft_nxt = body_bl;
      fleft_nxt = body_fl;
      if (body_tc != TC_LEVEL1) begin
        st = ST_ERR;
      end else if (body_ph == PH_BASE) begin
        acc_nxt   = {acc_eff[ACC_W-9:0], byte_in};
        bleft_nxt = body_bl - BASE_W'(1);
        if (bleft_nxt != '0) begin
          st = ST_MORE;
        end else if (body_fl == '0) begin
          st = ST_DONE;
        end else begin
          phase_nxt = PH_FRAC;
          st = ST_MORE;
        end
      end else begin
        fleft_nxt = body_fl - FRAC_W'(1);
        st = (fleft_nxt == '0) ? ST_DONE : ST_MORE;
      end
    end
  end

  // Epoch subtraction on the updated count
  assign acc64 = SECS_W'(acc_nxt);

  always_comb begin
    res.parse_status  = st;
    res.seconds_valid = 1'b0;
    res.dtn_seconds   = '0;
    if (st == ST_DONE && acc64 >= EPOCH_OFFSET) begin
      res.seconds_valid = 1'b1;
      res.dtn_seconds   = acc64 - EPOCH_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      type_r  <= '0;
      btot_r  <= '0;
      ftot_r  <= '0;
      bleft_r <= '0;
      fleft_r <= '0;
      acc_r   <= '0;
    end else if (step) begin
      if (st != ST_MORE) begin
        // done or error: back to start with everything cleared
        phase_r <= PH_START;
        type_r  <= '0;
        btot_r  <= '0;
        ftot_r  <= '0;
        bleft_r <= '0;
        fleft_r <= '0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        btot_r  <= btot_nxt;
        ftot_r  <= ftot_nxt;
        bleft_r <= bleft_nxt;
        fleft_r <= fleft_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule

>>> hdl/cuc_out_buf.sv
// Two-entry result register with skid slot between the parser and the output stream.
// Depends on cuc_pkg.
module cuc_out_buf
  import cuc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_vld_r, skid_vld_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop       = main_vld_r && out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // no push while the skid slot is full
      if (pop) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (push && main_vld_r && !pop) begin
      skid_vld_r <= 1'b1;
    end else if (push) begin
      main_vld_r <= 1'b1;
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push && main_vld_r && !pop) begin
      skid_r <= push_data;
    end else if (push) begin
      main_r <= push_data;
    end
  end

endmodule

>>> hdl/cuc_timecode_byte_parser.sv
// Top level of the CUC time code byte parser: config registers, parser core, output buffer.
// Depends on cuc_pkg, cuc_parse_core, cuc_out_buf.
//
//   channel | direction | payload
//   in_     | slave     | tdata[7:0] byte_in; tuser[0] first_byte
//   out_    | master    | tdata[1:0] parse_status, [65:2] dtn_seconds, [66] seconds_valid
//   cfg_    | write     | addr 0..3 selects register, wdata[3:0]
//
// One octet per cycle when ready; every accepted transaction yields exactly one result,
// registered and shown in the cycle after acceptance when the buffer is empty.
// Results sit in a two-entry buffer, so input stalls only when both entries are full.
// Reset (rst_n low, synchronous) returns the parser to start and loads config defaults.
module cuc_timecode_byte_parser
  import cuc_pkg::*;
#(
  parameter int unsigned MAX_BASE_OCTETS = 8,
  parameter int unsigned MAX_FRAC_OCTETS = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] byte_in
  input  logic                  in_tuser,   // [0] first_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] parse_status, [65:2] dtn_seconds,
                                            // [66] seconds_valid, [71:67] zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  result_t step_res, buf_res;
  logic    step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pfield_present      <= 1'b1;
      cfg_r.default_time_code   <= TC_LEVEL1;
      cfg_r.default_base_octets <= 4'd4;
      cfg_r.default_frac_octets <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PFIELD:   cfg_r.pfield_present      <= cfg_wdata[0];
        REG_DEF_TC:   cfg_r.default_time_code   <= cfg_wdata[2:0];
        REG_DEF_BASE: cfg_r.default_base_octets <= cfg_wdata[3:0];
        REG_DEF_FRAC: cfg_r.default_frac_octets <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign step = in_tvalid && in_tready;

  cuc_parse_core #(
    .MAX_BASE_OCTETS(MAX_BASE_OCTETS),
    .MAX_FRAC_OCTETS(MAX_FRAC_OCTETS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .byte_in   (in_tdata),
    .first_byte(in_tuser),
    .res       (step_res)
  );

  cuc_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .push_data(step_res),
    .can_push (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (buf_res)
  );

  assign out_tdata = {5'b0, buf_res};

endmodule

>>> hdl/cuc_checker.sv
// Port-level checks for cuc_timecode_byte_parser, bound to the top level.
// Depends on cuc_pkg.
module cuc_checker
  import cuc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a pending result may not change or vanish before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result seconds value only comes with a valid completion
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |-> out_tdata[1:0] == ST_DONE)
    else $error("seconds_valid without completion");

  a_secs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[66] |-> out_tdata[65:2] == '0)
    else $error("seconds nonzero while not valid");

  // input backpressure only when the result side is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // after each accepted transaction a result is pending in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

endmodule

bind cuc_timecode_byte_parser cuc_checker u_cuc_checker (.*);
